>>> rtl/fpst_pkg.sv
// Shared types and constants for the Fenwick prefix-sum table.
package fpst_pkg;

    localparam int IDX_W   = 10;
    localparam int DELTA_W = 16;
    localparam int SUM_W   = 48;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic walk;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic walk_ok;
        logic is_query;
    } t_dp_status;

endpackage

>>> rtl/fpst_datapath.sv
// Datapath of the Fenwick table: node store, walk position, accumulator.
module fpst_datapath
    import fpst_pkg::*;
#(
    parameter int TREE_SIZE = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic                      i_action,
    input  logic [IDX_W-1:0]          i_index,
    input  logic signed [DELTA_W-1:0] i_delta,
    output logic signed [SUM_W-1:0]   o_sum
);

    localparam int AW     = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;
    localparam int PW_MIN = AW + 2;
    localparam int PW     = (PW_MIN > IDX_W + 1) ? PW_MIN : IDX_W + 1;

    logic [SUM_W-1:0] r_mem [TREE_SIZE];

    logic [SUM_W-1:0] r_rdata;
    logic [AW-1:0]    r_clr;
    logic [PW-1:0]    r_pos;
    logic [AW-1:0]    r_pend_addr;
    logic             r_pend;
    logic             r_query;
    logic [SUM_W-1:0] r_amt;
    logic [SUM_W-1:0] r_acc;

    logic [PW-1:0]    n_pos;
    logic [PW-1:0]    n_load_pos;
    logic [PW-1:0]    idx_pos;
    logic [PW-1:0]    low_bit;
    logic [AW-1:0]    rd_addr;
    logic             walk_ok;
    logic             rd_en;

    assign idx_pos = PW'(i_index) + PW'(1);
    // Saturate an out-of-range query to the last position
    assign n_load_pos = (i_action == ACT_QUERY && idx_pos > PW'(TREE_SIZE)) ?
                        PW'(TREE_SIZE) : idx_pos;

    assign low_bit = r_pos & (~r_pos + PW'(1));
    assign walk_ok = r_query ? (r_pos != '0) : (r_pos <= PW'(TREE_SIZE));
    assign n_pos   = r_query ? (r_pos & (r_pos - PW'(1))) : (r_pos + low_bit);
    assign rd_addr = AW'(r_pos - PW'(1));
    assign rd_en   = i_cmd.walk && walk_ok;

    assign o_status.clr_last = (r_clr == AW'(TREE_SIZE - 1));
    assign o_status.walk_ok  = walk_ok;
    assign o_status.is_query = r_query;
    assign o_sum             = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_clr  <= '0;
        end else begin
            r_pend <= rd_en;
            if (i_cmd.clear) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_query <= i_action;
            r_pos   <= n_load_pos;
            r_amt   <= SUM_W'(i_delta);
            r_acc   <= '0;
        end
        if (rd_en) begin
            r_pos       <= n_pos;
            r_pend_addr <= rd_addr;
        end
        if (r_pend && r_query) begin
            r_acc <= r_acc + r_rdata;
        end
    end

    // One read and one write per cycle; a walk never revisits a node
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr] <= '0;
        end else if (r_pend && !r_query) begin
            r_mem[r_pend_addr] <= r_rdata + r_amt;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

>>> rtl/fpst_ctrl.sv
// Controller of the Fenwick table: clear pass, accept, walk sequencing.
module fpst_ctrl
    import fpst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK
    } t_state;

    t_state r_state;
    logic   r_valid;

    assign o_cmd.clear = (r_state == S_CLEAR);
    assign o_cmd.load  = (r_state == S_IDLE) && i_start;
    assign o_cmd.walk  = (r_state == S_WALK);
    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (i_status.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // Last node retires this cycle; present the sum next
                    if (!i_status.walk_ok) begin
                        r_state <= S_IDLE;
                        r_valid <= i_status.is_query;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

endmodule

>>> rtl/fenwick_prefix_sum_table_unit.sv
// Fenwick prefix-sum table: top level.
// After reset the unit clears its node store, one entry per cycle, and
// holds o_busy high until the last entry is cleared. An item is taken when
// i_start is high and o_busy is low. An update adds i_delta at i_index; an
// index at or beyond TREE_SIZE changes nothing. A query returns the sum of
// positions 0..i_index, saturated to the whole table, on o_prefix_sum for
// exactly one cycle marked by o_valid; the receiver cannot stall it. Each
// item walks the tree one node per cycle through the store's read port, N
// nodes with N at most log2(TREE_SIZE)+1, and o_busy stays high from the
// accept until the walk ends, so no new item is taken while one walks. A
// query result appears the cycle o_busy falls.
module fenwick_prefix_sum_table_unit
    import fpst_pkg::*;
#(
    parameter int TREE_SIZE = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_action,
    input  logic [IDX_W-1:0]          i_index,
    input  logic signed [DELTA_W-1:0] i_delta,
    output logic                      o_valid,
    output logic signed [SUM_W-1:0]   o_prefix_sum
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    fpst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    fpst_datapath #(
        .TREE_SIZE (TREE_SIZE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .i_action (i_action),
        .i_index  (i_index),
        .i_delta  (i_delta),
        .o_sum    (o_prefix_sum)
    );

endmodule

>>> rtl/fpst_checker.sv
// Port-level checks for the Fenwick prefix-sum table.
module fpst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // An accepted item keeps the unit busy for at least the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("unit not busy after accepting an item");

    // A result comes only as the unit finishes a walk
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(o_busy) && !o_busy))
        else $error("result strobe outside the end of a walk");

    // Strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // A strobe needs an item accepted before it
    a_valid_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !o_valid && !i_start) |=> !o_valid)
        else $error("result strobe without an item");

endmodule

bind fenwick_prefix_sum_table_unit fpst_checker u_fpst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);

>>> sim/fenwick_prefix_sum_table_unit_tb.sv
// Self-checking testbench for the Fenwick prefix-sum table unit.
`timescale 1ns / 1ps

module fenwick_prefix_sum_table_unit_tb;
    import fpst_pkg::*;

    localparam int TREE_SIZE   = 1024;
    localparam int RAND_ITEMS  = 1332;
    localparam int DIR_ROWS    = 21;
    localparam int TAIL_CYCLES = 16;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      i_action = ACT_ADD;
    logic [IDX_W-1:0]          i_index = '0;
    logic signed [DELTA_W-1:0] i_delta = '0;
    logic                      o_busy;
    logic                      o_valid;
    logic signed [SUM_W-1:0]   o_prefix_sum;

    typedef struct packed {
        logic               act;
        logic [IDX_W-1:0]   idx;
        logic [DELTA_W-1:0] dlt;
        logic               has_want;
        logic [SUM_W-1:0]   want;
    } t_dir_row;

    // Typed sums only where they follow directly from the rows above them.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ACT_QUERY, 10'd0,    16'h0000, 1'b1, 48'd0},
        '{ACT_QUERY, 10'd1023, 16'h0000, 1'b1, 48'd0},
        '{ACT_QUERY, 10'd512,  16'h7FFF, 1'b1, 48'd0},
        '{ACT_ADD,   10'd0,    16'h7FFF, 1'b0, 48'd0},
        '{ACT_QUERY, 10'd0,    16'h0000, 1'b1, 48'd32767},
        '{ACT_ADD,   10'd1023, 16'h8000, 1'b0, 48'd0},
        '{ACT_QUERY, 10'd1023, 16'h8000, 1'b1, 48'hFFFF_FFFF_FFFF},
        '{ACT_QUERY, 10'd1022, 16'hFFFF, 1'b1, 48'd32767},
        '{ACT_ADD,   10'd511,  16'hFFFF, 1'b0, 48'd0},
        '{ACT_QUERY, 10'd511,  16'h0000, 1'b1, 48'd32766},
        '{ACT_QUERY, 10'd510,  16'h0000, 1'b1, 48'd32767},
        '{ACT_ADD,   10'd512,  16'h0001, 1'b0, 48'd0},
        '{ACT_QUERY, 10'd1023, 16'h0000, 1'b1, 48'hFFFF_FFFF_FFFF},
        '{ACT_QUERY, 10'd512,  16'h0000, 1'b0, 48'd0},
        '{ACT_ADD,   10'd1,    16'h0000, 1'b0, 48'd0},
        '{ACT_QUERY, 10'd1,    16'h0000, 1'b0, 48'd0},
        '{ACT_ADD,   10'd682,  16'h5555, 1'b0, 48'd0},
        '{ACT_QUERY, 10'd681,  16'h0000, 1'b0, 48'd0},
        '{ACT_QUERY, 10'd682,  16'h0000, 1'b0, 48'd0},
        '{ACT_ADD,   10'd341,  16'hAAAA, 1'b0, 48'd0},
        '{ACT_QUERY, 10'd1023, 16'h0000, 1'b0, 48'd0}
    };

    logic [SUM_W-1:0] fen_node [1:TREE_SIZE];
    logic [SUM_W-1:0] pending_sums [$];
    int err_cnt   = 0;
    int n_updates = 0;
    int n_queries = 0;
    int n_checked = 0;

    fenwick_prefix_sum_table_unit #(
        .TREE_SIZE(TREE_SIZE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_action    (i_action),
        .i_index     (i_index),
        .i_delta     (i_delta),
        .o_valid     (o_valid),
        .o_prefix_sum(o_prefix_sum)
    );

    always #5 i_clk = ~i_clk;

    function automatic void node_add(input int unsigned idx,
                                     input logic signed [DELTA_W-1:0] dlt);
        int pos;
        logic [SUM_W-1:0] amount;
        amount = {{(SUM_W-DELTA_W){dlt[DELTA_W-1]}}, dlt};
        pos = idx + 1;
        while (pos >= 1 && pos <= TREE_SIZE) begin
            fen_node[pos] = fen_node[pos] + amount;
            pos = pos + (pos & -pos);
        end
    endfunction

    function automatic logic [SUM_W-1:0] prefix_total(input int unsigned idx);
        int pos;
        logic [SUM_W-1:0] acc;
        acc = '0;
        pos = idx + 1;
        if (pos > TREE_SIZE)
            pos = TREE_SIZE;
        while (pos > 0) begin
            acc = acc + fen_node[pos];
            pos = pos - (pos & -pos);
        end
        return acc;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return '0;
            1: return IDX_W'(TREE_SIZE - 1);
            2: return IDX_W'((1 << $urandom_range(IDX_W - 1)) - $urandom_range(1));
            default: return IDX_W'($urandom_range(TREE_SIZE - 1));
        endcase
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return DELTA_W'($urandom_range(16) - 8);
            default: return DELTA_W'($urandom);
        endcase
    endfunction

    // Hold the item until taken, then update the model or queue the sum.
    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [DELTA_W-1:0] dlt, input logic has_want,
                             input logic [SUM_W-1:0] want);
        i_start  <= 1'b1;
        i_action <= act;
        i_index  <= idx;
        i_delta  <= dlt;
        do @(posedge i_clk); while (o_busy);
        if (act == ACT_QUERY) begin
            pending_sums.insert(pending_sums.size(), has_want ? want : prefix_total(idx));
            n_queries++;
        end else begin
            node_add(idx, dlt);
            n_updates++;
        end
    endtask

    task automatic idle_gap(input int pct);
        if ($urandom_range(99) < pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < pct);
        end
    endtask

    // Drop start and hold off until every queued sum has come back or the max_cycles limit runs out.
    task automatic drain(input int max_cycles);
        int n;
        n = 0;
        i_start <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending_sums.size() != 0 && n < max_cycles);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected result: prefix_sum %0d", o_prefix_sum);
                err_cnt++;
            end else begin
                logic [SUM_W-1:0] want;
                want = pending_sums.pop_front();
                n_checked++;
                if (o_prefix_sum !== want) begin
                    $error("prefix_sum mismatch: expected %0d, actual %0d",
                           $signed(want), o_prefix_sum);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int idle_pct [3];
        int per_phase;
        logic act;
        idle_pct = '{18, 76, 0};
        per_phase = RAND_ITEMS / 3;
        for (int i = 1; i <= TREE_SIZE; i++)
            fen_node[i] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_item(dir_tab[r].act, dir_tab[r].idx, dir_tab[r].dlt,
                      dir_tab[r].has_want, dir_tab[r].want);
        drain(2000);

        for (int ph = 0; ph < 3; ph++) begin
            for (int k = 0; k < per_phase; k++) begin
                act = ($urandom_range(99) < 45) ? ACT_QUERY : ACT_ADD;
                send_item(act, pick_index(), pick_delta(), 1'b0, '0);
                idle_gap(idle_pct[ph]);
            end
            drain(2000);
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_sums.size() != 0) begin
            $error("prefix_sum: %0d expected results never arrived", pending_sums.size());
            err_cnt++;
        end

        $display("Ran %0d updates and %0d queries (%0d sums compared)",
                 n_updates, n_queries, n_checked);
        $display("over index and delta extremes, with light, heavy and no start gaps.");
        if (err_cnt == 0)
            $display("fenwick_prefix_sum_table_unit_tb: PASS");
        else
            $display("fenwick_prefix_sum_table_unit_tb: FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("fenwick_prefix_sum_table_unit_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fpst_pkg.sv
rtl/fpst_datapath.sv
rtl/fpst_ctrl.sv
rtl/fenwick_prefix_sum_table_unit.sv
rtl/fpst_checker.sv
sim/fenwick_prefix_sum_table_unit_tb.sv
